FILE: sv/b64enc_pkg.sv
// Package for the streaming Base64 encoder.
// Holds the request job type, queue sizing, pad code and the alphabet lookup.
// No dependencies.
`default_nettype none

package b64enc_pkg;

   // Depth of the job queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ASCII code of the '=' padding character.
   localparam logic [6:0] PAD_CODE = 7'd61;

   // Number of pending 2-bit pairs in the leftover register.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // One classified request: up to four characters to emit.
   typedef struct packed {
      logic [3:0][5:0] sextet;    // sextet values, character 0 in slot 0
      logic [3:0]      pad;       // slot emits '=' instead of a sextet
      logic [1:0]      last_idx;  // index of the last character of this request
      logic            fin;       // request ends a message
   } job_type;

   // Maps a 6-bit value to its ASCII character in the standard alphabet.
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] code;
      code = 7'd47;
      case (v) inside
         [6'd0:6'd25]:  code = 7'd65 + {1'b0, v};
         [6'd26:6'd51]: code = 7'd71 + {1'b0, v};
         [6'd52:6'd61]: code = {1'b0, v} - 7'd4;
         6'd62:         code = 7'd43;
         default:       code = 7'd47;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: sv/base64_stream_encoder_top.sv
// Streaming Base64 encoder, top level. Uses b64enc_pkg, b64enc_front,
// b64enc_queue and b64enc_back.
// The first character of a request passes through the job queue and then the
// output register before it reaches the result ports. Characters leave at one
// per cycle while pop drains the single output register; a request yields one
// to four characters, so requests are taken every cycle while the two-entry job
// queue has room. Reset clears the leftover bits, the job queue and the output valid flag.
`default_nettype none

module base64_stream_encoder_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_final_byte,
   output logic        empty,
   input  wire         pop,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last_char
);

   b64enc_pkg::job_type q_job;
   b64enc_pkg::job_type q_head;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;

   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (q_job)
   );

   b64enc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_job   (q_job),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

FILE: sv/b64enc_front.sv
// Front of the Base64 encoder: accepts bytes, keeps the leftover bits and
// turns each request into a job of up to four characters. Uses b64enc_pkg.
`default_nettype none

module b64enc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire  [7:0]             req_data_byte,
   input  wire                    req_final_byte,
   input  wire                    q_full,
   output logic                   q_push,
   output b64enc_pkg::job_type    q_job
);

   logic [3:0] leftover_ff, leftover_in;
   logic [1:0] pending_ff, pending_in;
   logic       accept;

   assign full   = q_full;
   assign accept = push & ~q_full;
   assign q_push = accept;

   // Split the joined bits into sextets and append flush and padding on a final byte.
   always_comb begin
      logic [9:0]  acc10;
      logic [11:0] acc12;
      acc10 = {leftover_ff[1:0], req_data_byte};
      acc12 = {leftover_ff, req_data_byte};
      q_job        = '0;
      leftover_in  = leftover_ff;
      pending_in   = pending_ff;
      case (pending_ff)
         b64enc_pkg::PEND_ONE: begin
            q_job.sextet[0] = acc10[9:4];
            if (req_final_byte) begin
               q_job.sextet[1] = {acc10[3:0], 2'b00};
               q_job.pad[2]    = 1'b1;
               q_job.last_idx  = 2'd2;
            end else begin
               q_job.last_idx  = 2'd0;
            end
            leftover_in = acc10[3:0];
            pending_in  = b64enc_pkg::PEND_TWO;
         end
         b64enc_pkg::PEND_TWO: begin
            q_job.sextet[0] = acc12[11:6];
            q_job.sextet[1] = acc12[5:0];
            q_job.last_idx  = 2'd1;
            leftover_in = 4'd0;
            pending_in  = b64enc_pkg::PEND_NONE;
         end
         default: begin
            q_job.sextet[0] = req_data_byte[7:2];
            if (req_final_byte) begin
               q_job.sextet[1] = {req_data_byte[1:0], 4'b0000};
               q_job.pad[2]    = 1'b1;
               q_job.pad[3]    = 1'b1;
               q_job.last_idx  = 2'd3;
            end else begin
               q_job.last_idx  = 2'd0;
            end
            leftover_in = {2'b00, req_data_byte[1:0]};
            pending_in  = b64enc_pkg::PEND_ONE;
         end
      endcase
      q_job.fin = req_final_byte;
      // A final byte leaves nothing pending for the next message.
      if (req_final_byte) begin
         leftover_in = 4'd0;
         pending_in  = b64enc_pkg::PEND_NONE;
      end
   end

   // Leftover state advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= 4'd0;
         pending_ff  <= b64enc_pkg::PEND_NONE;
      end else if (accept) begin
         leftover_ff <= leftover_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/b64enc_queue.sv
// Short job queue between the encoder front and back.
// Uses b64enc_pkg for the job type and queue depth.
`default_nettype none

module b64enc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_push,
   input  b64enc_pkg::job_type    q_job,
   output logic                   q_full,
   input  wire                    q_pop,
   output logic                   q_empty,
   output b64enc_pkg::job_type    q_head
);

   localparam int unsigned PTR_W = b64enc_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = b64enc_pkg::QUEUE_CNT_W;

   b64enc_pkg::job_type entry_ff [b64enc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(b64enc_pkg::QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push & ~q_full;
   assign do_pop  = q_pop & ~q_empty;

   // Pointer and fill count updates with wraparound at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(b64enc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(b64enc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_job;
      end
   end

endmodule

`default_nettype wire

FILE: sv/b64enc_back.sv
// Back of the Base64 encoder: steps through each queued job one character a cycle while
// the output register is free or popped, and holds the result in it. Uses b64enc_pkg.
`default_nettype none

module b64enc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_empty,
   input  b64enc_pkg::job_type    q_head,
   output logic                   q_pop,
   output logic                   empty,
   input  wire                    pop,
   output logic [6:0]             rsp_char_code,
   output logic                   rsp_last_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       advance, load, at_end;

   assign empty         = ~valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   // The output register takes a new character when it is free or being drained.
   assign advance = ~valid_ff | pop;
   assign load    = advance & ~q_empty;
   assign at_end  = (idx_ff == q_head.last_idx);
   assign q_pop   = load & at_end;

   // Pick the current character of the head job.
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = q_head.pad[idx_ff] ? b64enc_pkg::PAD_CODE
                                       : b64enc_pkg::sextet_char(q_head.sextet[idx_ff]);
         last_in  = q_head.fin & at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Character payload needs no reset.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire
